@@ src/tlsche_pkg.sv @@
// shared types and constants for the client hello field extractor
`timescale 1ns / 1ps
package tlsche_pkg;
	localparam int unsigned PosW = 16;
	localparam logic [PosW-1:0] PosLimit = {PosW{1'b1}};

	localparam logic [2:0] KIND_CIPHER = 3'd0;
	localparam logic [2:0] KIND_EXT    = 3'd1;
	localparam logic [2:0] KIND_CURVE  = 3'd2;
	localparam logic [2:0] KIND_SNI    = 3'd3;
	localparam logic [2:0] KIND_SUM    = 3'd4;

	localparam logic [2:0] STOP_OK       = 3'd0;
	localparam logic [2:0] STOP_SHORT    = 3'd1;
	localparam logic [2:0] STOP_NOT_HS   = 3'd2;
	localparam logic [2:0] STOP_NOT_HELO = 3'd3;
	localparam logic [2:0] STOP_TRUNC    = 3'd4;

	localparam logic [7:0] REC_HANDSHAKE = 8'd22;
	localparam logic [7:0] HS_CLIENT_HELLO = 8'd1;
	localparam logic [15:0] EXT_SNI = 16'h0000;
	localparam logic [15:0] EXT_GROUPS = 16'h000a;
	localparam logic [16:0] MIN_HELLO_LEN = 17'd47;
	localparam logic [16:0] SID_BASE = 17'd44;

	typedef enum logic [3:0] {
		PH_HEADER, PH_SID, PH_CIPHERS, PH_COMP, PH_EXT_HDR,
		PH_EXT_SKIP, PH_SNI, PH_CURVES, PH_DONE
	} phase_t;

	typedef struct packed {
		logic [7:0]  data_byte;
		logic [15:0] payload_len;
		logic        start_of_packet;
	} in_item_t;

	typedef struct packed {
		logic [2:0]  field_kind;
		logic [15:0] field_value;
		logic [15:0] record_version;
		logic [15:0] hello_version;
		logic        hello_valid;
		logic [2:0]  stop_code;
		logic        end_of_packet;
	} out_item_t;

	// what one byte produces: an optional field item and an optional summary
	typedef struct packed {
		logic      fld_en;
		out_item_t fld;
		logic      sum_en;
		out_item_t sum;
	} step_res_t;
endpackage

@@ src/tlsche_parser.sv @@
// per-byte parse state and field extraction
`timescale 1ns / 1ps
module tlsche_parser import tlsche_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      step,
	input  in_item_t  item,
	output step_res_t res
);
	logic [PosW-1:0] pos_q;
	phase_t phase_q;
	logic [7:0] shift_q;
	logic [16:0] sec_end_q, ext_end_q;
	logic [15:0] cur_ext_q, inner_q, rv_q, cv_q;
	logic [2:0] status_q;

	logic [PosW-1:0] pos_n;
	phase_t phase_n;
	logic [7:0] shift_n;
	logic [16:0] sec_end_n, ext_end_n;
	logic [15:0] cur_ext_n, inner_n, rv_n, cv_n;
	logic [2:0] status_n;

	logic [PosW-1:0] p;
	phase_t ph, pb;
	logic [7:0] sh, b;
	logic [16:0] se, ee, len, p17, o, p4;
	logic [15:0] ce, il, rv, cv, w;
	logic [2:0] st, code;
	logic live;

	always_comb begin
		b = item.data_byte;
		len = {1'b0, item.payload_len};
		if (item.start_of_packet) begin
			p = '0; ph = PH_HEADER; sh = '0; se = '0; ee = '0;
			ce = '0; il = '0; rv = '0; cv = '0; st = '0;
		end else begin
			p = pos_q; ph = phase_q; sh = shift_q; se = sec_end_q; ee = ext_end_q;
			ce = cur_ext_q; il = inner_q; rv = rv_q; cv = cv_q; st = status_q;
		end
		p17 = 17'(p);
		live = step && (p17 < len) && (p != PosLimit);
		w = {sh, b};
		pb = ph;
		if ((ph == PH_EXT_SKIP || ph == PH_SNI || ph == PH_CURVES) && p17 >= se)
			pb = PH_EXT_HDR;
		phase_n = pb; shift_n = sh; sec_end_n = se; ext_end_n = ee;
		cur_ext_n = ce; inner_n = il; rv_n = rv; cv_n = cv; status_n = st;
		res = '0;
		o = p17 - se;
		p4 = p17 + 17'd4;
		case (pb)
			PH_HEADER: begin
				case (p)
					PosW'(0): begin
						if (len < 17'd5) begin
							phase_n = PH_DONE; status_n = STOP_SHORT;
						end else if (b != REC_HANDSHAKE) begin
							phase_n = PH_DONE; status_n = STOP_NOT_HS;
						end
					end
					PosW'(1): begin
						if (b != 8'd3) begin
							phase_n = PH_DONE; status_n = STOP_NOT_HS;
						end
					end
					PosW'(2): begin
						rv_n = {8'h03, b};
						if (len < MIN_HELLO_LEN) begin
							phase_n = PH_DONE; status_n = STOP_SHORT;
						end
					end
					PosW'(5): begin
						if (b != HS_CLIENT_HELLO) begin
							phase_n = PH_DONE; status_n = STOP_NOT_HELO;
						end
					end
					PosW'(9): cv_n = {b, 8'h00};
					PosW'(10): cv_n = {cv[15:8], b};
					PosW'(43): begin
						sec_end_n = SID_BASE + 17'(b);
						phase_n = PH_SID;
					end
					default: ;
				endcase
			end
			PH_SID: begin
				if (p17 == se) shift_n = b;
				else if (p17 > se) begin
					inner_n = w;
					ext_end_n = p17 + 17'd1;
					sec_end_n = p17 + 17'd1 + 17'(w);
					phase_n = PH_CIPHERS;
				end
			end
			PH_CIPHERS: begin
				if (p17 < se) begin
					if (((p17 - ee) & 17'd1) == 17'd0) shift_n = b;
					else if (w != 16'd0) begin
						res.fld_en = 1'b1;
						res.fld.field_kind = KIND_CIPHER;
						res.fld.field_value = w;
					end
				end else begin
					sec_end_n = p17 + 17'd1 + 17'(b);
					phase_n = PH_COMP;
				end
			end
			PH_COMP: begin
				if (p17 == se) shift_n = b;
				else if (p17 > se) begin
					ext_end_n = p17 + 17'd1 + 17'(w);
					sec_end_n = p17 + 17'd1;
					phase_n = PH_EXT_HDR;
				end
			end
			PH_EXT_HDR: begin
				if (o == 17'd0) begin
					if (p4 > ee || p4 > len) begin
						phase_n = PH_DONE; status_n = STOP_OK;
					end else shift_n = b;
				end else if (o == 17'd1) begin
					cur_ext_n = w;
					res.fld_en = 1'b1;
					res.fld.field_kind = KIND_EXT;
					res.fld.field_value = w;
				end else if (o == 17'd2) shift_n = b;
				else begin
					sec_end_n = p17 + 17'd1 + 17'(w);
					inner_n = '0;
					if (ce == EXT_SNI && w > 16'd5 && sec_end_n <= len)
						phase_n = PH_SNI;
					else if (ce == EXT_GROUPS && w >= 16'd2 && sec_end_n <= len)
						phase_n = PH_CURVES;
					else
						phase_n = PH_EXT_SKIP;
					cur_ext_n = '0;
				end
			end
			PH_SNI: begin
				if (il == 16'd3) shift_n = b;
				else if (il == 16'd4)
					cur_ext_n = (p17 + 17'd1 + 17'(w) <= se) ? w : 16'd0;
				else if (il >= 16'd5 && (il - 16'd5) < ce) begin
					res.fld_en = 1'b1;
					res.fld.field_kind = KIND_SNI;
					res.fld.field_value = {8'h00, b};
				end
				if (il != 16'hffff) inner_n = il + 16'd1;
			end
			PH_CURVES: begin
				if (il == 16'd0) shift_n = b;
				else if (il == 16'd1) cur_ext_n = w;
				else if (!il[0]) shift_n = b;
				else if (17'(il) < 17'(ce) + 17'd2) begin
					res.fld_en = 1'b1;
					res.fld.field_kind = KIND_CURVE;
					res.fld.field_value = w;
				end
				if (il != 16'hffff) inner_n = il + 16'd1;
			end
			default: ;
		endcase
		if (phase_n == PH_DONE) code = status_n;
		else if (phase_n == PH_HEADER) code = STOP_SHORT;
		else if (phase_n < PH_EXT_HDR) code = STOP_TRUNC;
		else code = STOP_OK;
		res.sum_en = live && (p17 == len - 17'd1);
		res.sum.field_kind = KIND_SUM;
		res.sum.record_version = rv_n;
		res.sum.hello_version = (code == STOP_OK || code == STOP_TRUNC) ? cv_n : 16'd0;
		res.sum.hello_valid = (code == STOP_OK);
		res.sum.stop_code = code;
		res.sum.end_of_packet = 1'b1;
		res.fld_en = res.fld_en && live;
		pos_n = p + PosW'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0; phase_q <= PH_HEADER; shift_q <= '0; sec_end_q <= '0;
			ext_end_q <= '0; cur_ext_q <= '0; inner_q <= '0; rv_q <= '0;
			cv_q <= '0; status_q <= '0;
		end else if (step) begin
			if (live) begin
				pos_q <= pos_n; phase_q <= phase_n; shift_q <= shift_n;
				sec_end_q <= sec_end_n; ext_end_q <= ext_end_n; cur_ext_q <= cur_ext_n;
				inner_q <= inner_n; rv_q <= rv_n; cv_q <= cv_n; status_q <= status_n;
			end else if (item.start_of_packet) begin
				pos_q <= '0; phase_q <= PH_HEADER; shift_q <= '0; sec_end_q <= '0;
				ext_end_q <= '0; cur_ext_q <= '0; inner_q <= '0; rv_q <= '0;
				cv_q <= '0; status_q <= '0;
			end
		end
	end
endmodule

@@ src/tls_client_hello_field_extractor_unit.sv @@
// top level: input register, parser, four-entry result queue
//  channel | valid    | ready    | payload
//  input   | in_valid | in_ready | in_data  (in_item_t)
//  output  | out_valid| out_ready| out_data (out_item_t)
// one byte per cycle while the queue has room for two results; a byte is held in the
// input register and its results go into a four-entry output queue, up to two a byte
// reset clears parse state, the input register and the queue; stalls on output
// back up the input register, so in_ready drops only when the queue cannot take two more
`timescale 1ns / 1ps
module tls_client_hello_field_extractor_unit import tlsche_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_item_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_data
);
	in_item_t item_s1;
	logic v_s1;
	step_res_t res;
	out_item_t fifo_q [4];
	logic [1:0] rd_q, wr_q;
	logic [2:0] cnt_q;
	logic adv, pop;
	logic [1:0] nput;

	// stage 1 may advance when queue has room for two results
	assign adv = (cnt_q - {2'b0, pop}) <= 3'd2;
	assign in_ready = !v_s1 || adv;
	assign pop = out_valid && out_ready;
	assign out_valid = cnt_q != 3'd0;
	assign out_data = fifo_q[rd_q];

	tlsche_parser u_parser (
		.clk(clk), .arst_n(arst_n), .step(v_s1 && adv), .item(item_s1), .res(res)
	);

	assign nput = (v_s1 && adv) ? 2'(res.fld_en) + 2'(res.sum_en) : 2'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (in_ready) v_s1 <= in_valid;
	end
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) item_s1 <= in_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q <= '0; wr_q <= '0; cnt_q <= '0;
		end else begin
			rd_q <= rd_q + 2'(pop);
			wr_q <= wr_q + nput;
			cnt_q <= cnt_q + 3'(nput) - 3'(pop);
		end
	end
	always_ff @(posedge clk) begin
		if (v_s1 && adv) begin
			if (res.fld_en) fifo_q[wr_q] <= res.fld;
			if (res.sum_en) fifo_q[wr_q + 2'(res.fld_en)] <= res.sum;
		end
	end
endmodule

@@ src/tlsche_checker.sv @@
// port-level checks for the extractor, bound to the top level
`timescale 1ns / 1ps
module tlsche_checker import tlsche_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      in_valid,
	input logic      in_ready,
	input logic      out_valid,
	input logic      out_ready,
	input out_item_t out_data
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("output transfer dropped while stalled");
	a_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.field_kind <= KIND_SUM)
		else $error("bad field kind");
	a_eop: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.end_of_packet == (out_data.field_kind == KIND_SUM))
		else $error("end of packet not on summary");
	a_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.hello_valid |-> out_data.stop_code == STOP_OK)
		else $error("valid hello with stop code");
	// an empty queue never holds off the input
	a_idle_ready: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !out_valid |-> in_ready)
		else $error("input stalled with empty queue");
endmodule

bind tls_client_hello_field_extractor_unit tlsche_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);
